// ===== sv/framed_axis_packet_receiver_top_defines.svh =====
// assertion macros shared by the packet receiver checkers
`ifndef FRAMED_AXIS_PACKET_RECEIVER_TOP_DEFINES_SVH
`define FRAMED_AXIS_PACKET_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FAPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fapr check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FAPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fapr check failed");

`endif

// ===== sv/fapr_pkg.sv =====
// types, constants and codes of the framed axis packet receiver
package fapr_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int AXIS_COUNT   = 6;
  localparam int FRAME_BYTES  = HEADER_BYTES + 4 * AXIS_COUNT + 1;
  localparam int COUNT_W      = $clog2(FRAME_BYTES + 1);
  localparam int AXIS_IDX_W   = $clog2(AXIS_COUNT);
  localparam int AXIS_OFF_W   = AXIS_IDX_W + 2;
  localparam int TICKS_W      = 17;
  localparam int AXIS_W       = 32;

  localparam logic [7:0]         HEADER_MARK     = 8'hff;
  localparam logic [7:0]         BUTTON_RESERVED = 8'hfe;
  localparam logic [TICKS_W-1:0] TICKS_MAX       = '1;
  localparam logic [TICKS_W-1:0] LIMIT_RESET     = TICKS_W'(50000);

  // event kinds on the input tuser
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_IDLE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // configuration register indexes
  localparam logic REG_TIMEOUT_LIMIT = 1'b0;

  localparam int CFG_ADDR_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_BITS   = 1 + AXIS_COUNT * AXIS_W + 1 + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic             valid;
    logic [1:0]       opcode;
    logic [7:0]       byte_value;
  } fapr_event_t;

  typedef struct packed {
    logic                                new_packet;
    logic [AXIS_COUNT-1:0][AXIS_W-1:0]   axes;
    logic                                button_state;
    logic                                link_timed_out;
  } fapr_result_t;

endpackage

// ===== sv/fapr_cfg.sv =====
// apb configuration register holding the timeout limit
module fapr_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fapr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [fapr_pkg::TICKS_W-1:0]        timeout_limit
);
  import fapr_pkg::*;

  logic [TICKS_W-1:0] limit_r;
  logic               hit;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_ADDR_W-1:2] == REG_TIMEOUT_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      limit_r <= pwdata[TICKS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(32 - TICKS_W){1'b0}}, limit_r};
    end
  end

  assign timeout_limit = limit_r;

endmodule

// ===== sv/fapr_core.sv =====
// frame collection, held values and silence counter
module fapr_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fapr_pkg::fapr_event_t         evt,
  input  logic [fapr_pkg::TICKS_W-1:0]  timeout_limit,
  output fapr_pkg::fapr_result_t        result
);
  import fapr_pkg::*;

  logic [COUNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                               hdr_r, hdr_nxt;
  logic                               trl_r, trl_nxt;
  logic [AXIS_COUNT-1:0][AXIS_W-1:0]  pend_r;
  logic                               pend_btn_r;
  logic [AXIS_COUNT-1:0][AXIS_W-1:0]  held_r, held_nxt;
  logic                               held_btn_r, held_btn_nxt;
  logic [TICKS_W-1:0]                 ticks_r, ticks_nxt;
  logic                               axis_we, btn_we, fresh;
  logic [COUNT_W-1:0]                 off;
  logic [AXIS_IDX_W-1:0]              idx;
  logic [1:0]                         lane;
  logic [TICKS_W:0]                   cap, inc;

  assign off  = cnt_r - COUNT_W'(HEADER_BYTES);
  assign idx  = off[AXIS_OFF_W-1:2];
  assign lane = off[1:0];

  always_comb begin
    cnt_nxt      = cnt_r;
    hdr_nxt      = hdr_r;
    trl_nxt      = trl_r;
    held_nxt     = held_r;
    held_btn_nxt = held_btn_r;
    ticks_nxt    = ticks_r;
    axis_we      = 1'b0;
    btn_we       = 1'b0;
    fresh        = 1'b0;
    cap = (timeout_limit < TICKS_MAX) ? ({1'b0, timeout_limit} + 1'b1) : {1'b0, TICKS_MAX};
    inc = {1'b0, ticks_r} + 1'b1;
    unique case (evt.opcode)
      OP_BYTE: begin
        // bytes past a full frame are dropped
        if (cnt_r < COUNT_W'(FRAME_BYTES)) begin
          if (cnt_r < COUNT_W'(HEADER_BYTES)) begin
            if (evt.byte_value != HEADER_MARK) hdr_nxt = 1'b0;
          end else if (cnt_r < COUNT_W'(FRAME_BYTES - 1)) begin
            axis_we = 1'b1;
          end else begin
            trl_nxt = ((evt.byte_value & BUTTON_RESERVED) == 8'h00);
            btn_we  = 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_IDLE: begin
        if (cnt_r == COUNT_W'(FRAME_BYTES) && hdr_r && trl_r) begin
          held_nxt     = pend_r;
          held_btn_nxt = pend_btn_r;
          ticks_nxt    = '0;
          fresh        = 1'b1;
        end
        cnt_nxt = '0;
        hdr_nxt = 1'b1;
        trl_nxt = 1'b1;
      end
      OP_TICK: begin
        // saturate at limit + 1, or at all ones
        ticks_nxt = (inc > cap) ? cap[TICKS_W-1:0] : inc[TICKS_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      hdr_r      <= 1'b1;
      trl_r      <= 1'b1;
      held_r     <= '0;
      held_btn_r <= 1'b0;
      ticks_r    <= '0;
    end else if (evt.valid) begin
      cnt_r      <= cnt_nxt;
      hdr_r      <= hdr_nxt;
      trl_r      <= trl_nxt;
      held_r     <= held_nxt;
      held_btn_r <= held_btn_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

  // pending frame payload, overwritten byte by byte, no reset
  always_ff @(posedge clk) begin
    if (evt.valid && axis_we) begin
      pend_r[idx][{lane, 3'b000} +: 8] <= evt.byte_value;
    end
    if (evt.valid && btn_we) begin
      pend_btn_r <= evt.byte_value[0];
    end
  end

  always_comb begin
    result.new_packet     = fresh;
    result.axes           = held_nxt;
    result.button_state   = held_btn_nxt;
    result.link_timed_out = (ticks_nxt > timeout_limit);
  end

endmodule

// ===== sv/fapr_outbuf.sv =====
// result register between the core and the output stream
module fapr_outbuf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  fapr_pkg::fapr_result_t            result,
  output logic                              room,
  output logic                              tvalid,
  input  logic                              tready,
  output logic [fapr_pkg::OUT_DATA_W-1:0]   tdata
);
  import fapr_pkg::*;

  logic                  vld_r;
  logic [OUT_BITS-1:0]   data_r;

  // a new result may enter when empty or when the held one leaves now
  assign room = !vld_r || tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (room) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      data_r <= {result.link_timed_out, result.button_state,
                 result.axes, result.new_packet};
    end
  end

  assign tvalid = vld_r;
  assign tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, data_r};

endmodule

// ===== sv/framed_axis_packet_receiver_top.sv =====
// top level of the framed axis packet receiver
//
//  channel  | direction | handshake            | contents
//  ---------+-----------+----------------------+-----------------------------------
//  in_      | slave     | in_tvalid/in_tready  | tuser event kind, tdata byte
//  out_     | master    | out_tvalid/out_tready| flag, six axes, button, timeout
//  cfg_     | apb slave | psel/penable/pready  | timeout_limit at byte address 0
//
// every transfer on in_ yields exactly one registered transfer on out_
// one transfer per cycle sustained while out_ does not stall; state update and
// result register load on the same in_ transfer, so in_tready is only the room
// check of the result register (empty, or emptied by out_tready this cycle)
// a stall on out_ holds the result and drops in_tready until it is taken
// synchronous active-low reset: frame restarts, held axes, button and the
// silence count go to zero, the limit goes to 50000
module framed_axis_packet_receiver_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fapr_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] byte_value
  input  logic [fapr_pkg::IN_USER_W-1:0]     in_tuser,   // [1:0] opcode
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] new_packet, [32:1] axis_zero, [64:33] axis_one, [96:65] axis_two,
  // [128:97] axis_three, [160:129] axis_four, [192:161] axis_five,
  // [193] button_state, [194] link_timed_out, [199:195] zero
  output logic [fapr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fapr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import fapr_pkg::*;

  logic               room;
  logic               in_fire;
  logic [TICKS_W-1:0] timeout_limit;
  fapr_event_t        evt;
  fapr_result_t       result;

  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;

  // event handed to the core on every input transfer
  always_comb begin
    evt.valid      = in_fire;
    evt.opcode     = in_tuser;
    evt.byte_value = in_tdata;
  end

  fapr_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .timeout_limit (timeout_limit)
  );

  // frame state and held values, result formed from the next state
  fapr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt           (evt),
    .timeout_limit (timeout_limit),
    .result        (result)
  );

  // result register, decouples out_tready from the core
  fapr_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_fire),
    .result (result),
    .room   (room),
    .tvalid (out_tvalid),
    .tready (out_tready),
    .tdata  (out_tdata)
  );

endmodule

// ===== sv/fapr_checker.sv =====
// port-level checks of the packet receiver, bound to the top level
`include "framed_axis_packet_receiver_top_defines.svh"

module fapr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [fapr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic                               cfg_psel,
  input logic                               cfg_penable,
  input logic                               cfg_pwrite,
  input logic [fapr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input logic [31:0]                        cfg_pwdata,
  input logic [31:0]                        cfg_prdata,
  input logic                               cfg_pready
);
  import fapr_pkg::*;

  // an empty result register always takes the next transfer
  `FAPR_ASSERT_IMP(a_room_when_empty, !out_tvalid, in_tready)

  // a stalled result stays put
  `FAPR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata))

  // a fresh frame clears the silence count, so it can never report a timeout
  `FAPR_ASSERT_IMP(a_fresh_not_timed_out, out_tvalid && out_tdata[0],
                   !out_tdata[OUT_BITS-1])

  // a limit write reads back on the next cycle
  `FAPR_ASSERT_NXT(a_limit_readback,
                   cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                   (cfg_paddr[CFG_ADDR_W-1:2] == REG_TIMEOUT_LIMIT),
                   (cfg_paddr[CFG_ADDR_W-1:2] != REG_TIMEOUT_LIMIT) ||
                   (cfg_prdata[TICKS_W-1:0] == $past(cfg_pwdata[TICKS_W-1:0])))

endmodule

bind framed_axis_packet_receiver_top fapr_checker u_fapr_checker (.*);

// ===== tb/tb_framed_axis_packet_receiver_top.sv =====
// self-checking testbench of the framed axis packet receiver: frames, idles, ticks and the limit
module tb_framed_axis_packet_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fapr_pkg::*;

  // event kind that the block leaves without effect
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // byte address of the timeout limit register
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(4 * int'(REG_TIMEOUT_LIMIT));

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [7:0] byte_value
  logic [IN_USER_W-1:0]  in_tuser = '0;    // [1:0] opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  // [0] new_packet, [32:1]..[192:161] axis_zero..axis_five,
  // [193] button_state, [194] link_timed_out
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  framed_axis_packet_receiver_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver state as the testbench tracks it
  int                                rx_count = 0;
  logic                              hdr_ok = 1'b1;
  logic                              btn_ok = 1'b1;
  logic [AXIS_COUNT-1:0][AXIS_W-1:0] frame_axes = '0;
  logic                              frame_button = 1'b0;
  logic [AXIS_COUNT-1:0][AXIS_W-1:0] shown_axes = '0;
  logic                              shown_button = 1'b0;
  logic [TICKS_W-1:0]                quiet_ticks = '0;
  logic [TICKS_W-1:0]                limit_now = LIMIT_RESET;

  fapr_result_t pending_results[$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  packets_taken = 0;
  int  timeouts_seen = 0;
  int  events_sent = 0;
  // when set, neither side inserts gaps
  bit  steady = 1'b0;

  // ------------------------------------------------------------------
  // prediction: advance the tracked state by one event, return the result
  // ------------------------------------------------------------------
  function automatic fapr_result_t advance_receiver(logic [1:0] op, logic [7:0] b);
    fapr_result_t     r;
    int               off;
    logic             fresh;
    logic [TICKS_W:0] cap;
    logic [TICKS_W:0] next_q;
    fresh = 1'b0;
    case (op)
      OP_BYTE: begin
        // bytes past a full frame are dropped
        if (rx_count < FRAME_BYTES) begin
          if (rx_count < HEADER_BYTES) begin
            if (b != HEADER_MARK) hdr_ok = 1'b0;
          end else if (rx_count < FRAME_BYTES - 1) begin
            off = rx_count - HEADER_BYTES;
            frame_axes[off / 4][(off % 4) * 8 +: 8] = b;
          end else begin
            btn_ok = (b & BUTTON_RESERVED) == 8'd0;
            frame_button = b[0];
          end
          rx_count++;
        end
      end
      OP_IDLE: begin
        if (rx_count == FRAME_BYTES && hdr_ok && btn_ok) begin
          shown_axes = frame_axes;
          shown_button = frame_button;
          quiet_ticks = '0;
          fresh = 1'b1;
        end
        // idle always restarts collection
        rx_count = 0;
        hdr_ok = 1'b1;
        btn_ok = 1'b1;
      end
      OP_TICK: begin
        // saturate at limit + 1, or at all ones; a lowered limit pulls the count down
        cap = (limit_now < TICKS_MAX) ? {1'b0, limit_now} + 1'b1 : {1'b0, TICKS_MAX};
        next_q = {1'b0, quiet_ticks} + 1'b1;
        quiet_ticks = (next_q > cap) ? cap[TICKS_W-1:0] : next_q[TICKS_W-1:0];
      end
      default: begin
        // unused kind: nothing moves
      end
    endcase
    r.new_packet = fresh;
    r.axes = shown_axes;
    r.button_state = shown_button;
    r.link_timed_out = quiet_ticks > limit_now;
    return r;
  endfunction

  function automatic fapr_result_t split_result(logic [OUT_DATA_W-1:0] d);
    fapr_result_t r;
    r.new_packet = d[0];
    for (int i = 0; i < AXIS_COUNT; i++) r.axes[i] = d[1 + AXIS_W * i +: AXIS_W];
    r.button_state = d[1 + AXIS_COUNT * AXIS_W];
    r.link_timed_out = d[2 + AXIS_COUNT * AXIS_W];
    return r;
  endfunction

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch at %0t: %s expected %h, got %h", $time, field, want, got);
    mismatches++;
  endtask

  task automatic compare_result(fapr_result_t got);
    fapr_result_t want;
    if (pending_results.size() == 0) begin
      if (mismatches < 10) $display("result transfer with nothing pending at %0t", $time);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (want.new_packet) packets_taken++;
    if (want.link_timed_out) timeouts_seen++;
    if (got.new_packet !== want.new_packet)
      note_mismatch("new_packet", 32'(want.new_packet), 32'(got.new_packet));
    for (int i = 0; i < AXIS_COUNT; i++)
      if (got.axes[i] !== want.axes[i])
        note_mismatch($sformatf("axis %0d", i), want.axes[i], got.axes[i]);
    if (got.button_state !== want.button_state)
      note_mismatch("button_state", 32'(want.button_state), 32'(got.button_state));
    if (got.link_timed_out !== want.link_timed_out)
      note_mismatch("link_timed_out", 32'(want.link_timed_out), 32'(got.link_timed_out));
  endtask

  // ------------------------------------------------------------------
  // port watcher: predict on each input transfer, check each result transfer
  // both are sampled at the rising edge, before the block updates
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) pending_results.push_back(advance_receiver(in_tuser, in_tdata));
      if (out_tvalid && out_tready) compare_result(split_result(out_tdata));
    end
  end

  // result side back-pressure: random stalls, none while steady
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // ------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------

  // one event on the input channel; tvalid stays high after the transfer so
  // back-to-back events never lower and raise it in the same step
  task automatic push_event(logic [1:0] op, logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    events_sent++;
  endtask

  // drop tvalid and wait until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic read_limit_check(logic [TICKS_W-1:0] want);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= LIMIT_ADDR;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(want)) note_mismatch("timeout_limit readback", 32'(want), cfg_prdata);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // register write only with the block idle, then read back
  task automatic write_limit(int value);
    drain_results();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= LIMIT_ADDR;
    cfg_pwdata <= 32'(value);
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_now = value[TICKS_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    read_limit_check(value[TICKS_W-1:0]);
  endtask

  // header, six little-endian words and the button byte; no idle
  task automatic send_word_frame(logic [AXIS_COUNT-1:0][AXIS_W-1:0] words, logic [7:0] btn);
    repeat (HEADER_BYTES) push_event(OP_BYTE, HEADER_MARK);
    for (int i = 0; i < AXIS_COUNT; i++)
      for (int k = 0; k < 4; k++) push_event(OP_BYTE, words[i][8 * k +: 8]);
    push_event(OP_BYTE, btn);
  endtask

  // occasional tick or unused event inside a frame; the frame is not disturbed
  task automatic sprinkle();
    if ($urandom_range(0, 9) == 0) push_event(OP_TICK, 8'($urandom));
    if ($urandom_range(0, 39) == 0) push_event(OP_UNUSED, 8'($urandom));
  endtask

  // one random sequence: mostly good frames, some broken ones and plain noise
  task automatic send_random_sequence();
    logic [7:0] frame[FRAME_BYTES];
    logic [31:0] word;
    int len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      repeat ($urandom_range(3, 20)) push_event(2'($urandom), 8'($urandom));
      return;
    end
    for (int i = 0; i < HEADER_BYTES; i++) frame[i] = HEADER_MARK;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      case ($urandom_range(0, 9))
        0: word = 32'h8000_0000;
        1: word = 32'h7fff_ffff;
        2: word = 32'hffff_ffff;
        3: word = 32'h0000_0000;
        default: word = $urandom;
      endcase
      for (int k = 0; k < 4; k++) frame[HEADER_BYTES + 4 * i + k] = word[8 * k +: 8];
    end
    frame[FRAME_BYTES - 1] = 8'($urandom_range(0, 1));
    len = FRAME_BYTES;
    if (r < 14) begin
      // one header byte other than the mark
      frame[$urandom_range(0, HEADER_BYTES - 1)] = 8'($urandom_range(0, 254));
    end else if (r < 22) begin
      // reserved button bits set
      frame[FRAME_BYTES - 1] = 8'($urandom_range(2, 255));
    end else if (r < 30) begin
      len = $urandom_range(0, FRAME_BYTES - 1);
    end else if (r < 36) begin
      len = FRAME_BYTES + $urandom_range(1, 5);
    end
    for (int i = 0; i < len; i++) begin
      sprinkle();
      push_event(OP_BYTE, (i < FRAME_BYTES) ? frame[i] : 8'($urandom));
    end
    sprinkle();
    push_event(OP_IDLE, 8'($urandom));
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // reset values: held outputs zero, limit reads back its reset value
  task automatic test_reset_state();
    read_limit_check(LIMIT_RESET);
    push_event(OP_UNUSED, 8'hff);
    push_event(OP_IDLE, 8'h00);
  endtask

  // extreme axis values, dropped extra bytes, short frames, idle on nothing
  task automatic test_frame_handling();
    logic [AXIS_COUNT-1:0][AXIS_W-1:0] extremes;
    extremes = {32'hffff_fffe, 32'h0000_0001, 32'hffff_ffff,
                32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_word_frame(extremes, 8'h01);
    push_event(OP_TICK, 8'h55);
    push_event(OP_BYTE, 8'h00);      // past a full frame: dropped
    push_event(OP_UNUSED, 8'haa);
    push_event(OP_IDLE, 8'hff);      // accepted
    push_event(OP_BYTE, HEADER_MARK);
    push_event(OP_BYTE, HEADER_MARK);
    push_event(OP_IDLE, 8'h00);      // short frame: nothing taken
    push_event(OP_IDLE, 8'h00);      // idle with no bytes at all
    send_word_frame(~extremes, 8'h00);
    push_event(OP_IDLE, 8'h00);      // button back to zero
  endtask

  // silence counting, saturation, lowered limit, and a small and a large limit
  task automatic test_silence_limit();
    write_limit(1);
    repeat (3) push_event(OP_TICK, 8'h00);
    send_word_frame({AXIS_COUNT{32'h1234_5678}}, 8'h01);
    push_event(OP_IDLE, 8'h00);      // clears the count
    push_event(OP_TICK, 8'h00);
    write_limit(20);
    repeat (15) push_event(OP_TICK, 8'h00);
    write_limit(3);
    push_event(OP_TICK, 8'h00);      // pulled down to the new ceiling
    write_limit(100);
    push_event(OP_UNUSED, 8'h00);
    write_limit(100000);
    repeat (3) push_event(OP_TICK, 8'h00);
    send_word_frame({AXIS_COUNT{32'h0f0f_f0f0}}, 8'h00);
    push_event(OP_IDLE, 8'h00);
  endtask

  // random frames in phases with different limits
  task automatic test_random_traffic();
    int limits[5];
    int goal;
    limits[0] = 50000;
    limits[1] = 1;
    limits[2] = $urandom_range(2, 40);
    limits[3] = 100000;
    limits[4] = $urandom_range(1, 100000);
    foreach (limits[p]) begin
      write_limit(limits[p]);
      goal = events_sent + 200;
      while (events_sent < goal) begin
        steady = ($urandom_range(0, 6) == 0);
        send_random_sequence();
      end
      steady = 1'b0;
    end
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    int waited;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_frame_handling();
    test_silence_limit();
    test_random_traffic();

    // let every outstanding result arrive
    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    $display("checked %0d results from %0d input transfers", results_checked, events_sent);
    $display("frames accepted %0d, results with link timed out %0d, mismatches %0d",
             packets_taken, timeouts_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
